/* hdl/assert_macros.svh */
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// invariant checked at every clock outside reset
`define SPQ_ASSERT_ALWAYS(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// consequent checked in the cycle after the antecedent
`define SPQ_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* hdl/spq_pkg.sv */
package spq_pkg;

  localparam int VAL_W  = 32;
  localparam int PRI_W  = 16;
  localparam int STAT_W = 2;
  localparam int OCC_W  = 5;

  localparam logic OP_ENQ = 1'b0;
  localparam logic OP_DEQ = 1'b1;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK    = 2'd0,
    STAT_EMPTY = 2'd1,
    STAT_FULL  = 2'd2
  } status_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] value;
    logic        [PRI_W-1:0] prio;
  } entry_t;

  typedef struct packed {
    logic   push;
    logic   pop;
    entry_t item;
  } cell_cmd_t;

endpackage

/* hdl/spq_in_if.sv */
interface spq_in_if;
  logic                             valid;
  logic                             ready;
  logic                             operation;
  logic signed [spq_pkg::VAL_W-1:0] item_value;
  logic        [spq_pkg::PRI_W-1:0] item_priority;

  modport source (output valid, operation, item_value, item_priority, input ready);
  modport sink   (input valid, operation, item_value, item_priority, output ready);
endinterface

/* hdl/spq_out_if.sv */
interface spq_out_if;
  logic                              valid;
  logic                              ready;
  logic        [spq_pkg::STAT_W-1:0] status;
  logic signed [spq_pkg::VAL_W-1:0]  out_value;
  logic        [spq_pkg::PRI_W-1:0]  out_priority;
  logic        [spq_pkg::OCC_W-1:0]  occupancy;

  modport source (output valid, status, out_value, out_priority, occupancy, input ready);
  modport sink   (input valid, status, out_value, out_priority, occupancy, output ready);
endinterface

/* hdl/spq_cell.sv */
module spq_cell (
  input  logic               clk,
  input  spq_pkg::cell_cmd_t cmd,
  input  logic               occupied,
  input  logic               left_ahead,
  input  spq_pkg::entry_t    left_entry,
  input  spq_pkg::entry_t    right_entry,
  output logic               ahead,
  output spq_pkg::entry_t    entry
);

  spq_pkg::entry_t entry_r;
  spq_pkg::entry_t entry_nxt;

  // stored entry is served ahead of the incoming one
  assign ahead = occupied && (entry_r.prio < cmd.item.prio);
  assign entry = entry_r;

  always_comb begin
    entry_nxt = entry_r;
    if (cmd.push) begin
      if (!ahead) begin
        entry_nxt = left_ahead ? cmd.item : left_entry;
      end
    end else if (cmd.pop) begin
      entry_nxt = right_entry;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

endmodule

/* hdl/sorted_priority_queue.sv */
// the result word of an accepted word is registered and valid in the cycle after
// one word per cycle unless stalled, all cells compare and shift in the same cycle
// input is taken while the result register is empty or being drained
// reset (rst_n low, synchronous) empties the queue and drops any pending result
// cell contents are not cleared; only entries below the count are ever read
module sorted_priority_queue #(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  spq_in_if.sink    in_ch,
  spq_out_if.source out_ch
);

  `include "assert_macros.svh"

  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int OW    = spq_pkg::OCC_W;

  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] count_nxt;
  logic             out_valid_r;
  logic             out_valid_nxt;

  logic [spq_pkg::STAT_W-1:0]       out_status_r;
  logic signed [spq_pkg::VAL_W-1:0] out_value_r;
  logic [spq_pkg::PRI_W-1:0]        out_prio_r;
  logic [OW-1:0]                    out_occ_r;

  logic               acc;
  logic               is_pop;
  logic               full;
  logic               empty;
  spq_pkg::status_t   status;
  spq_pkg::cell_cmd_t cmd;

  spq_pkg::entry_t cell_entry [QUEUE_DEPTH];
  logic            cell_ahead [QUEUE_DEPTH];

  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign acc         = in_ch.valid && in_ch.ready;
  assign is_pop      = (in_ch.operation == spq_pkg::OP_DEQ);
  assign full        = (count_r == CNT_W'(QUEUE_DEPTH));
  assign empty       = (count_r == '0);

  always_comb begin
    cmd.push       = acc && !is_pop && !full;
    cmd.pop        = acc && is_pop && !empty;
    cmd.item.value = in_ch.item_value;
    cmd.item.prio  = in_ch.item_priority;

    count_nxt = count_r;
    if (cmd.push) begin
      count_nxt = count_r + 1'b1;
    end else if (cmd.pop) begin
      count_nxt = count_r - 1'b1;
    end

    if (is_pop) begin
      status = empty ? spq_pkg::STAT_EMPTY : spq_pkg::STAT_OK;
    end else begin
      status = full ? spq_pkg::STAT_FULL : spq_pkg::STAT_OK;
    end

    out_valid_nxt = out_valid_r;
    if (acc) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    logic            left_ahead;
    spq_pkg::entry_t left_entry;
    spq_pkg::entry_t right_entry;
    logic            occupied;

    assign occupied = (CNT_W'(i) < count_r);

    if (i == 0) begin : g_head
      assign left_ahead = 1'b1;
      assign left_entry = cmd.item;
    end else begin : g_body
      assign left_ahead = cell_ahead[i-1];
      assign left_entry = cell_entry[i-1];
    end

    if (i == QUEUE_DEPTH - 1) begin : g_tail
      assign right_entry = cell_entry[i];
    end else begin : g_mid
      assign right_entry = cell_entry[i+1];
    end

    spq_cell u_cell (
      .clk         (clk),
      .cmd         (cmd),
      .occupied    (occupied),
      .left_ahead  (left_ahead),
      .left_entry  (left_entry),
      .right_entry (right_entry),
      .ahead       (cell_ahead[i]),
      .entry       (cell_entry[i])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      out_status_r <= status;
      out_value_r  <= cmd.pop ? cell_entry[0].value : '0;
      out_prio_r   <= cmd.pop ? cell_entry[0].prio : '0;
      out_occ_r    <= OW'(count_nxt);
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.status       = out_status_r;
  assign out_ch.out_value    = out_value_r;
  assign out_ch.out_priority = out_prio_r;
  assign out_ch.occupancy    = out_occ_r;

  `SPQ_ASSERT_ALWAYS(a_count_bound, count_r <= CNT_W'(QUEUE_DEPTH), "count beyond depth")
  `SPQ_ASSERT_NEXT(a_push_count, cmd.push, count_r == $past(count_r) + 1'b1, "push count")
  `SPQ_ASSERT_NEXT(a_pop_front, cmd.pop, out_value_r == $past(cell_entry[0].value), "pop value")
  `SPQ_ASSERT_ALWAYS(a_front_order,
                     count_r < CNT_W'(2) || cell_entry[0].prio <= cell_entry[1].prio, "order")

endmodule

/* test/sorted_priority_queue_tb.sv */
module sorted_priority_queue_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int QDEPTH       = 16;
  localparam int RANDOM_WORDS = 530;
  localparam int TAIL_WORDS   = 80;
  localparam int LONG_HOLD    = 120;
  localparam int CYCLE_LIMIT  = 150000;

  typedef struct packed {
    spq_pkg::status_t                 status;
    logic signed [spq_pkg::VAL_W-1:0] value;
    logic        [spq_pkg::PRI_W-1:0] prio;
    logic        [spq_pkg::OCC_W-1:0] occ;
  } result_t;

  typedef struct packed {
    logic                             op;
    logic signed [spq_pkg::VAL_W-1:0] value;
    logic        [spq_pkg::PRI_W-1:0] prio;
    logic        [4:0]                reps;
    logic                             typed;
    result_t                          exp;
  } stim_row_t;

  localparam result_t NO_RESULT = '0;

  // directed words; rows with reps above one step value up and priority down, wrapping every six
  localparam stim_row_t DIRECTED [9] = '{
    '{spq_pkg::OP_DEQ, 32'sh7fffffff, 16'hffff, 5'd1, 1'b1,
      '{spq_pkg::STAT_EMPTY, 32'sd0, 16'd0, 5'd0}},
    '{spq_pkg::OP_ENQ, 32'sh7fffffff, 16'hffff, 5'd1, 1'b1,
      '{spq_pkg::STAT_OK, 32'sd0, 16'd0, 5'd1}},
    '{spq_pkg::OP_ENQ, 32'sh80000000, 16'h0000, 5'd1, 1'b1,
      '{spq_pkg::STAT_OK, 32'sd0, 16'd0, 5'd2}},
    '{spq_pkg::OP_ENQ, 32'sd11,       16'h0005, 5'd1, 1'b0, NO_RESULT},
    '{spq_pkg::OP_ENQ, 32'sd22,       16'h0005, 5'd1, 1'b0, NO_RESULT},
    '{spq_pkg::OP_ENQ, 32'sd1000,     16'h0100, 5'd12, 1'b0, NO_RESULT},
    '{spq_pkg::OP_ENQ, 32'sh5a5a5a5a, 16'h0001, 5'd1, 1'b1,
      '{spq_pkg::STAT_FULL, 32'sd0, 16'd0, 5'd16}},
    '{spq_pkg::OP_DEQ, 32'sh00000000, 16'h0000, 5'd1, 1'b1,
      '{spq_pkg::STAT_OK, 32'sh80000000, 16'd0, 5'd15}},
    '{spq_pkg::OP_DEQ, 32'shffffffff, 16'hffff, 5'd2, 1'b0, NO_RESULT}
  };

  localparam int ENQ_BIAS [11] = '{85, 15, 55, 95, 5, 50, 70, 25, 90, 40, 50};

  logic clk = 1'b0;
  logic rst_n;

  spq_in_if  in_ch ();
  spq_out_if out_ch ();

  sorted_priority_queue DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch.sink),
    .out_ch (out_ch.source)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  spq_pkg::entry_t held [QDEPTH];
  int              held_count = 0;
  result_t         expected_results [$];
  int              mismatch_count = 0;
  int              cycle_count = 0;
  bit              quiet_tail = 1'b0;
  bit              hold_req = 1'b0;

  function automatic result_t queue_step(input logic op,
                                         input logic signed [spq_pkg::VAL_W-1:0] val,
                                         input logic [spq_pkg::PRI_W-1:0] pri);
    result_t r;
    int pos;
    r = '0;
    r.status = spq_pkg::STAT_OK;
    if (op == spq_pkg::OP_ENQ) begin
      if (held_count >= QDEPTH) begin
        r.status = spq_pkg::STAT_FULL;
      end else begin
        pos = 0;
        while (pos < held_count && held[pos].prio < pri) pos++;
        for (int k = held_count; k > pos; k--) held[k] = held[k-1];
        held[pos].value = val;
        held[pos].prio  = pri;
        held_count++;
      end
    end else if (held_count == 0) begin
      r.status = spq_pkg::STAT_EMPTY;
    end else begin
      r.value = held[0].value;
      r.prio  = held[0].prio;
      for (int k = 1; k < held_count; k++) held[k-1] = held[k];
      held_count--;
    end
    r.occ = spq_pkg::OCC_W'(held_count);
    return r;
  endfunction

  task automatic send_word(input logic op, input logic signed [spq_pkg::VAL_W-1:0] val,
                           input logic [spq_pkg::PRI_W-1:0] pri, input logic typed,
                           input result_t typed_exp);
    result_t predicted;
    in_ch.valid         <= 1'b1;
    in_ch.operation     <= op;
    in_ch.item_value    <= val;
    in_ch.item_priority <= pri;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    predicted = queue_step(op, val, pri);
    expected_results.push_back(typed ? typed_exp : predicted);
  endtask

  task automatic idle(input int cycles);
    in_ch.valid <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // result checker
  always @(posedge clk) begin
    result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected result word: status %0d value %0d prio %0d occ %0d",
                   out_ch.status, out_ch.out_value, out_ch.out_priority, out_ch.occupancy);
      end else begin
        want = expected_results.pop_front();
        if (out_ch.status !== want.status || out_ch.out_value !== want.value ||
            out_ch.out_priority !== want.prio || out_ch.occupancy !== want.occ) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("result word differs: expected %0d %0d %0d %0d, got %0d %0d %0d %0d",
                     want.status, want.value, want.prio, want.occ, out_ch.status,
                     out_ch.out_value, out_ch.out_priority, out_ch.occupancy);
        end
      end
    end
  end

  // result sink: random stalls plus one long hold on request
  initial begin : result_sink
    int stall_left;
    stall_left = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (stall_left > 0) begin
        stall_left--;
      end else if (hold_req) begin
        stall_left = LONG_HOLD;
        hold_req = 1'b0;
      end else if (!quiet_tail && $urandom_range(0, 11) == 0) begin
        stall_left = $urandom_range(1, 19);
      end
      out_ch.ready <= (stall_left == 0);
    end
  end

  initial begin : word_source
    stim_row_t row;
    logic op;
    logic signed [spq_pkg::VAL_W-1:0] val;
    logic [spq_pkg::PRI_W-1:0] pri;
    bit burst_window;

    rst_n               <= 1'b0;
    in_ch.valid         <= 1'b0;
    in_ch.operation     <= spq_pkg::OP_ENQ;
    in_ch.item_value    <= '0;
    in_ch.item_priority <= '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (DIRECTED[r]) begin
      row = DIRECTED[r];
      for (int i = 0; i < int'(row.reps); i++)
        send_word(row.op, row.value + spq_pkg::VAL_W'(i),
                  row.prio - spq_pkg::PRI_W'(i % 6), row.typed, row.exp);
    end

    for (int n = 0; n < RANDOM_WORDS; n++) begin
      quiet_tail = (n >= RANDOM_WORDS - TAIL_WORDS);
      burst_window = (n >= 100 && n < 140);
      if (n == 100) hold_req = 1'b1;
      if (n == 300) begin
        idle(1);
        wait (expected_results.size() == 0);
        @(posedge clk);
      end

      op = ($urandom_range(0, 99) < ENQ_BIAS[(n / 50) % 11]) ? spq_pkg::OP_ENQ
                                                             : spq_pkg::OP_DEQ;
      case ($urandom_range(0, 7))
        0:       val = 32'sh80000000;
        1:       val = 32'sh7fffffff;
        default: val = $urandom();
      endcase
      case ($urandom_range(0, 5))
        0, 1:    pri = spq_pkg::PRI_W'($urandom_range(0, 7));
        2:       pri = $urandom_range(0, 1) ? '1 : '0;
        default: pri = spq_pkg::PRI_W'($urandom());
      endcase

      if (!quiet_tail && !burst_window && $urandom_range(0, 9) == 0)
        idle($urandom_range(1, 19));
      send_word(op, val, pri, 1'b0, NO_RESULT);
    end

    idle(1);
    wait (expected_results.size() == 0);
    repeat (8) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

/* filelist.f */
+incdir+hdl
hdl/spq_pkg.sv
hdl/spq_in_if.sv
hdl/spq_out_if.sv
hdl/spq_cell.sv
hdl/sorted_priority_queue.sv
test/sorted_priority_queue_tb.sv
